// ----- rtl/core/ttep_pkg.sv -----
// ----------------------------------------------------------------------------
// ttep_pkg
// Types, constants and helpers shared by the time expression parser modules.
// ----------------------------------------------------------------------------
package ttep_pkg;

  localparam int CHAR_W    = 8;
  localparam int LEAD_W    = 40;
  localparam int MIN_W     = 7;
  localparam int FRM_W     = 7;
  localparam int SUB_W     = 20;
  localparam int CNT_W     = 5;
  localparam int MUL_W     = 32;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DNUM_W    = 64;
  localparam int DDEN_W    = 56;
  localparam int DCNT_W    = 7;
  localparam int TIME_W    = 63;
  localparam int FR_W      = 10;
  localparam int TR_W      = 24;
  localparam int DEN_W     = 30;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  localparam logic [LEAD_W-1:0] LEAD_MAX = '1;
  localparam logic [SUB_W-1:0]  SUB_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  // microsecond scale factors
  localparam logic [MUL_W-1:0] K_HOUR = 32'd3600000000;
  localparam logic [MUL_W-1:0] K_MIN  = 32'd60000000;
  localparam logic [MUL_W-1:0] K_SEC  = 32'd1000000;
  localparam logic [MUL_W-1:0] K_MS   = 32'd1000;

  // characters of the grammar
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_H     = 8'h68;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
  localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h74;

  // register indexes
  localparam logic [1:0] REG_FRAME_RATE    = 2'd0;
  localparam logic [1:0] REG_SUBFRAME_RATE = 2'd1;
  localparam logic [1:0] REG_TICK_RATE     = 2'd2;

  typedef enum logic [3:0] {
    PH_LEAD, PH_MIN, PH_SEC, PH_CFRAC, PH_FRM, PH_SUB, PH_OFRAC, PH_UNIT, PH_ERR
  } phase_t;

  typedef enum logic [2:0] {
    U_H, U_M, U_S, U_MS, U_F, U_T
  } unit_t;

  typedef enum logic [4:0] {
    S_IDLE, S_EVAL, S_LP1, S_LP2, S_LP3,
    S_OF1, S_OF2, S_OF3,
    S_RT1, S_RT2, S_RT3, S_RT4, S_RT5, S_RT6,
    S_CK1, S_CK2, S_CK3, S_CF1,
    S_FR1, S_FR2, S_FR3,
    S_SB1, S_SB2, S_SB3, S_SB4,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    MA_LEAD_HI, MA_LEAD_LO, MA_FRAC, MA_REM, MA_DEN, MA_MIN, MA_SEC, MA_FRM, MA_SUB,
    MA_SR
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_LEADK, MB_UNITK, MB_US, MB_MINK, MB_DEN, MB_RATE, MB_FR
  } mul_b_t;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_CLR, ACC_PROD, ACC_ADDM, ACC_ADDQ, ACC_LOADQ
  } acc_op_t;

  typedef enum logic [1:0] {
    T_NONE, T_LOADM, T_ADDM
  } t_op_t;

  typedef enum logic [1:0] {
    DN_M, DN_ACC, DN_T
  } div_num_t;

  typedef enum logic [2:0] {
    DD_DEN, DD_RATE, DD_FR, DD_M, DD_T
  } div_den_t;

  typedef struct packed {
    logic     parse;
    logic     clr_parse;
    logic     eval;
    logic     mul_en;
    mul_a_t   mul_a;
    mul_b_t   mul_b;
    acc_op_t  acc_op;
    t_op_t    t_op;
    logic     div_start;
    div_num_t div_num;
    div_den_t div_den;
  } cmd_t;

  typedef struct packed {
    logic   ok;
    phase_t phase;
    logic   rate_unit;
    logic   div_done;
  } status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              last_char;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_us;
    logic              malformed;
  } out_item_t;

  // ten to the power of the fraction digit count
  function automatic logic [DEN_W-1:0] pow10(input logic [3:0] d);
    logic [DEN_W-1:0] v;
    case (d)
      4'd0:    v = 30'd1;
      4'd1:    v = 30'd10;
      4'd2:    v = 30'd100;
      4'd3:    v = 30'd1000;
      4'd4:    v = 30'd10000;
      4'd5:    v = 30'd100000;
      4'd6:    v = 30'd1000000;
      4'd7:    v = 30'd10000000;
      4'd8:    v = 30'd100000000;
      default: v = 30'd1000000000;
    endcase
    return v;
  endfunction

  // saturating add into the time accumulator
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [PROD_W-1:0] b);
    logic [PROD_W:0] s;
    s = {2'b00, a} + {1'b0, b};
    if (s > {2'b00, TIME_MAX}) begin
      return TIME_MAX;
    end
    return s[TIME_W-1:0];
  endfunction

endpackage

// ----- rtl/core/timed_text_time_expression_parser.sv -----
// ----------------------------------------------------------------------------
// timed_text_time_expression_parser
// Timed-text time expression to microseconds converter.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one character per request, last_char marks the end of the
//           expression. Characters are taken at one per cycle while in_ready is high.
//   out_* : one result per expression, time in microseconds and a malformed
//           flag (time zero when malformed).
//   APB   : frame_rate at 0x0, subframe_rate at 0x4, tick_rate at 0x8; a rate
//           written as zero acts as one.
// A malformed expression goes straight to its result; every division runs on
// the shared bit-serial divider.
// While a result is computed or waits, in_ready is low; a stalled receiver
// simply holds the result, and the next expression starts the cycle after
// it is taken. Reset returns the rates to 30, 1 and 1 and starts a new
// expression.
// ----------------------------------------------------------------------------
module timed_text_time_expression_parser #(
  parameter int MAX_FRACTION_DIGITS = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ttep_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ttep_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ttep_pkg::CFG_AW-1:0]   paddr,
  input  logic [ttep_pkg::CFG_DW-1:0]   pwdata,
  output logic [ttep_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  logic [ttep_pkg::FR_W-1:0] frame_rate_r, subframe_rate_r;
  logic [ttep_pkg::TR_W-1:0] tick_rate_r;
  logic                      wr_en;

  // register writes
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rate_r    <= ttep_pkg::FR_W'(30);
      subframe_rate_r <= ttep_pkg::FR_W'(1);
      tick_rate_r     <= ttep_pkg::TR_W'(1);
    end else if (wr_en) begin
      case (paddr[3:2])
        ttep_pkg::REG_FRAME_RATE:    frame_rate_r    <= pwdata[ttep_pkg::FR_W-1:0];
        ttep_pkg::REG_SUBFRAME_RATE: subframe_rate_r <= pwdata[ttep_pkg::FR_W-1:0];
        ttep_pkg::REG_TICK_RATE:     tick_rate_r     <= pwdata[ttep_pkg::TR_W-1:0];
        default:                     tick_rate_r     <= tick_rate_r;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      ttep_pkg::REG_FRAME_RATE:    prdata = ttep_pkg::CFG_DW'(frame_rate_r);
      ttep_pkg::REG_SUBFRAME_RATE: prdata = ttep_pkg::CFG_DW'(subframe_rate_r);
      ttep_pkg::REG_TICK_RATE:     prdata = ttep_pkg::CFG_DW'(tick_rate_r);
      default:                     prdata = '0;
    endcase
  end

  ttep_pkg::cmd_t    cmd;
  ttep_pkg::status_t sts;

  ttep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_char),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttep_dp #(
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_data       (in_data),
    .frame_rate    (frame_rate_r),
    .subframe_rate (subframe_rate_r),
    .tick_rate     (tick_rate_r),
    .out_data      (out_data)
  );

endmodule

// ----- rtl/core/ttep_div.sv -----
// ----------------------------------------------------------------------------
// ttep_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ttep_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ttep_pkg::DNUM_W-1:0] num,
  input  logic [ttep_pkg::DDEN_W-1:0] den,
  output logic                        done,
  output logic [ttep_pkg::DNUM_W-1:0] quo,
  output logic [ttep_pkg::DDEN_W-1:0] rem
);

  logic [ttep_pkg::DNUM_W-1:0] quo_r, quo_nxt;
  logic [ttep_pkg::DDEN_W-1:0] rem_r, rem_nxt, den_r;
  logic [ttep_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt, done_r, done_nxt;
  logic [ttep_pkg::DDEN_W:0]   rem_sh;

  // one shift and trial subtract per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    rem_sh   = {rem_r, quo_r[ttep_pkg::DNUM_W-1]};
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = ttep_pkg::DDEN_W'(rem_sh - {1'b0, den_r});
        quo_nxt = {quo_r[ttep_pkg::DNUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[ttep_pkg::DDEN_W-1:0];
        quo_nxt = {quo_r[ttep_pkg::DNUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ttep_pkg::DCNT_W'(ttep_pkg::DNUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand and working registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/core/ttep_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttep_ctrl
// Sequencer: takes characters, then steps the datapath through the scaling.
// ----------------------------------------------------------------------------
module ttep_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ttep_pkg::status_t sts,
  output ttep_pkg::cmd_t    cmd
);

  ttep_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttep_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ttep_pkg::S_IDLE: begin
        if (in_valid && in_last) begin
          state_nxt = ttep_pkg::S_EVAL;
        end
      end
      ttep_pkg::S_EVAL: state_nxt = sts.ok ? ttep_pkg::S_LP1 : ttep_pkg::S_OUT;
      ttep_pkg::S_LP1:  state_nxt = ttep_pkg::S_LP2;
      ttep_pkg::S_LP2:  state_nxt = ttep_pkg::S_LP3;
      ttep_pkg::S_LP3: begin
        if (sts.phase == ttep_pkg::PH_UNIT) begin
          state_nxt = sts.rate_unit ? ttep_pkg::S_RT1 : ttep_pkg::S_OF1;
        end else begin
          state_nxt = ttep_pkg::S_CK1;
        end
      end
      ttep_pkg::S_OF1: state_nxt = ttep_pkg::S_OF2;
      ttep_pkg::S_OF2: state_nxt = ttep_pkg::S_OF3;
      ttep_pkg::S_OF3: if (sts.div_done) state_nxt = ttep_pkg::S_OUT;
      ttep_pkg::S_RT1: state_nxt = ttep_pkg::S_RT2;
      ttep_pkg::S_RT2: if (sts.div_done) state_nxt = ttep_pkg::S_RT3;
      ttep_pkg::S_RT3: state_nxt = ttep_pkg::S_RT4;
      ttep_pkg::S_RT4: state_nxt = ttep_pkg::S_RT5;
      ttep_pkg::S_RT5: state_nxt = ttep_pkg::S_RT6;
      ttep_pkg::S_RT6: if (sts.div_done) state_nxt = ttep_pkg::S_OUT;
      ttep_pkg::S_CK1: state_nxt = ttep_pkg::S_CK2;
      ttep_pkg::S_CK2: state_nxt = ttep_pkg::S_CK3;
      ttep_pkg::S_CK3: begin
        case (sts.phase)
          ttep_pkg::PH_CFRAC:              state_nxt = ttep_pkg::S_CF1;
          ttep_pkg::PH_FRM, ttep_pkg::PH_SUB: state_nxt = ttep_pkg::S_FR1;
          default:                         state_nxt = ttep_pkg::S_OUT;
        endcase
      end
      ttep_pkg::S_CF1: state_nxt = ttep_pkg::S_OF2;
      ttep_pkg::S_FR1: state_nxt = ttep_pkg::S_FR2;
      ttep_pkg::S_FR2: state_nxt = ttep_pkg::S_FR3;
      ttep_pkg::S_FR3: begin
        if (sts.div_done) begin
          state_nxt = (sts.phase == ttep_pkg::PH_SUB) ? ttep_pkg::S_SB1 : ttep_pkg::S_OUT;
        end
      end
      ttep_pkg::S_SB1: state_nxt = ttep_pkg::S_SB2;
      ttep_pkg::S_SB2: state_nxt = ttep_pkg::S_SB3;
      ttep_pkg::S_SB3: state_nxt = ttep_pkg::S_SB4;
      ttep_pkg::S_SB4: if (sts.div_done) state_nxt = ttep_pkg::S_OUT;
      ttep_pkg::S_OUT: if (out_ready) state_nxt = ttep_pkg::S_IDLE;
      default:         state_nxt = ttep_pkg::S_IDLE;
    endcase
  end

  // datapath commands and handshake outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ttep_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.parse = in_valid;
      end
      ttep_pkg::S_EVAL: begin
        cmd.eval   = 1'b1;
        cmd.acc_op = ttep_pkg::ACC_CLR;
      end
      ttep_pkg::S_LP1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = ttep_pkg::MA_LEAD_HI;
        cmd.mul_b  = ttep_pkg::MB_LEADK;
      end
      ttep_pkg::S_LP2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = ttep_pkg::MA_LEAD_LO;
        cmd.mul_b  = ttep_pkg::MB_LEADK;
        cmd.t_op   = ttep_pkg::T_LOADM;
      end
      ttep_pkg::S_LP3: cmd.acc_op = ttep_pkg::ACC_PROD;
      ttep_pkg::S_OF1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = ttep_pkg::MA_FRAC;
        cmd.mul_b  = ttep_pkg::MB_UNITK;
      end
      ttep_pkg::S_OF2: begin
        cmd.div_start = 1'b1;
        cmd.div_num   = ttep_pkg::DN_M;
        cmd.div_den   = ttep_pkg::DD_DEN;
      end
      ttep_pkg::S_OF3, ttep_pkg::S_RT6, ttep_pkg::S_SB4: begin
        if (sts.div_done) cmd.acc_op = ttep_pkg::ACC_ADDQ;
      end
      ttep_pkg::S_RT1: begin
        cmd.div_start = 1'b1;
        cmd.div_num   = ttep_pkg::DN_ACC;
        cmd.div_den   = ttep_pkg::DD_RATE;
      end
      ttep_pkg::S_RT2: begin
        if (sts.div_done) begin
          cmd.acc_op = ttep_pkg::ACC_LOADQ;
          cmd.mul_en = 1'b1;
          cmd.mul_a  = ttep_pkg::MA_REM;
          cmd.mul_b  = ttep_pkg::MB_DEN;
        end
      end
      ttep_pkg::S_RT3: begin
        cmd.t_op   = ttep_pkg::T_LOADM;
        cmd.mul_en = 1'b1;
        cmd.mul_a  = ttep_pkg::MA_FRAC;
        cmd.mul_b  = ttep_pkg::MB_US;
      end
      ttep_pkg::S_RT4: begin
        cmd.t_op   = ttep_pkg::T_ADDM;
        cmd.mul_en = 1'b1;
        cmd.mul_a  = ttep_pkg::MA_DEN;
        cmd.mul_b  = ttep_pkg::MB_RATE;
      end
      ttep_pkg::S_RT5: begin
        cmd.div_start = 1'b1;
        cmd.div_num   = ttep_pkg::DN_T;
        cmd.div_den   = ttep_pkg::DD_M;
      end
      ttep_pkg::S_CK1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = ttep_pkg::MA_MIN;
        cmd.mul_b  = ttep_pkg::MB_MINK;
      end
      ttep_pkg::S_CK2: begin
        cmd.acc_op = ttep_pkg::ACC_ADDM;
        cmd.mul_en = 1'b1;
        cmd.mul_a  = ttep_pkg::MA_SEC;
        cmd.mul_b  = ttep_pkg::MB_US;
      end
      ttep_pkg::S_CK3: cmd.acc_op = ttep_pkg::ACC_ADDM;
      ttep_pkg::S_CF1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = ttep_pkg::MA_FRAC;
        cmd.mul_b  = ttep_pkg::MB_US;
      end
      ttep_pkg::S_FR1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = ttep_pkg::MA_FRM;
        cmd.mul_b  = ttep_pkg::MB_US;
      end
      ttep_pkg::S_FR2: begin
        cmd.div_start = 1'b1;
        cmd.div_num   = ttep_pkg::DN_M;
        cmd.div_den   = ttep_pkg::DD_FR;
      end
      ttep_pkg::S_FR3: begin
        if (sts.div_done) cmd.acc_op = ttep_pkg::ACC_ADDQ;
      end
      ttep_pkg::S_SB1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = ttep_pkg::MA_SR;
        cmd.mul_b  = ttep_pkg::MB_FR;
      end
      ttep_pkg::S_SB2: begin
        cmd.t_op   = ttep_pkg::T_LOADM;
        cmd.mul_en = 1'b1;
        cmd.mul_a  = ttep_pkg::MA_SUB;
        cmd.mul_b  = ttep_pkg::MB_US;
      end
      ttep_pkg::S_SB3: begin
        cmd.div_start = 1'b1;
        cmd.div_num   = ttep_pkg::DN_M;
        cmd.div_den   = ttep_pkg::DD_T;
      end
      ttep_pkg::S_OUT: begin
        out_valid     = 1'b1;
        cmd.clr_parse = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/core/ttep_dp.sv -----
// ----------------------------------------------------------------------------
// ttep_dp
// Datapath: character parser, field registers, multiplier, accumulator and
// the shared divider.
// ----------------------------------------------------------------------------
module ttep_dp #(
  parameter int MAX_FRACTION_DIGITS = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ttep_pkg::cmd_t              cmd,
  output ttep_pkg::status_t           sts,
  input  ttep_pkg::in_item_t          in_data,
  input  logic [ttep_pkg::FR_W-1:0]   frame_rate,
  input  logic [ttep_pkg::FR_W-1:0]   subframe_rate,
  input  logic [ttep_pkg::TR_W-1:0]   tick_rate,
  output ttep_pkg::out_item_t         out_data
);

  localparam int FRAC_W = $clog2(10 ** MAX_FRACTION_DIGITS);
  localparam int FD_W   = $clog2(MAX_FRACTION_DIGITS + 1);

  ttep_pkg::phase_t                 phase_r, phase_nxt;
  ttep_pkg::unit_t                  unit_r, unit_nxt;
  logic [ttep_pkg::LEAD_W-1:0]      lead_r, lead_nxt;
  logic [ttep_pkg::MIN_W-1:0]       min_r, min_nxt, sec_r, sec_nxt;
  logic [ttep_pkg::FRM_W-1:0]       frm_r, frm_nxt;
  logic [ttep_pkg::SUB_W-1:0]       sub_r, sub_nxt;
  logic [FRAC_W-1:0]                frac_r, frac_nxt;
  logic [FD_W-1:0]                  fd_r, fd_nxt;
  logic [ttep_pkg::CNT_W-1:0]       cnt_r, cnt_nxt, cnt_inc;
  logic [ttep_pkg::TIME_W-1:0]      acc_r;
  logic                             mal_r;

  logic [ttep_pkg::CHAR_W-1:0]      c;
  logic                             dig, is_unit;
  logic [3:0]                       d;
  ttep_pkg::unit_t                  unit_c;
  logic [ttep_pkg::LEAD_W+3:0]      lead10;
  logic [ttep_pkg::SUB_W+3:0]       sub10;
  logic [FRAC_W+3:0]                frac10;

  // ---- character parser ----
  assign c       = in_data.char_in;
  assign dig     = (c inside {[ttep_pkg::CH_0:ttep_pkg::CH_9]});
  assign d       = dig ? c[3:0] : 4'd0;
  assign lead10  = ({4'b0, lead_r} << 3) + ({4'b0, lead_r} << 1)
                   + (ttep_pkg::LEAD_W + 4)'(d);
  assign sub10   = ({4'b0, sub_r} << 3) + ({4'b0, sub_r} << 1)
                   + (ttep_pkg::SUB_W + 4)'(d);
  assign frac10  = ({4'b0, frac_r} << 3) + ({4'b0, frac_r} << 1) + (FRAC_W + 4)'(d);
  assign cnt_inc = (cnt_r == ttep_pkg::CNT_MAX) ? cnt_r : cnt_r + 1'b1;

  // unit letters
  always_comb begin
    is_unit = 1'b1;
    case (c)
      ttep_pkg::CH_H: unit_c = ttep_pkg::U_H;
      ttep_pkg::CH_M: unit_c = ttep_pkg::U_M;
      ttep_pkg::CH_S: unit_c = ttep_pkg::U_S;
      ttep_pkg::CH_F: unit_c = ttep_pkg::U_F;
      ttep_pkg::CH_T: unit_c = ttep_pkg::U_T;
      default: begin
        unit_c  = ttep_pkg::U_H;
        is_unit = 1'b0;
      end
    endcase
  end

  // next parse state
  always_comb begin
    phase_nxt = phase_r;
    unit_nxt  = unit_r;
    lead_nxt  = lead_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    frm_nxt   = frm_r;
    sub_nxt   = sub_r;
    frac_nxt  = frac_r;
    fd_nxt    = fd_r;
    cnt_nxt   = cnt_r;
    if (cmd.clr_parse) begin
      phase_nxt = ttep_pkg::PH_LEAD;
      unit_nxt  = ttep_pkg::U_H;
      lead_nxt  = '0;
      min_nxt   = '0;
      sec_nxt   = '0;
      frm_nxt   = '0;
      sub_nxt   = '0;
      frac_nxt  = '0;
      fd_nxt    = '0;
      cnt_nxt   = '0;
    end else if (cmd.parse) begin
      case (phase_r)
        ttep_pkg::PH_LEAD: begin
          if (dig) begin
            lead_nxt = (lead10 > {4'b0, ttep_pkg::LEAD_MAX}) ? ttep_pkg::LEAD_MAX
                                                            : lead10[ttep_pkg::LEAD_W-1:0];
            cnt_nxt  = cnt_inc;
          end else if (c == ttep_pkg::CH_COLON && cnt_r >= 5'd2) begin
            phase_nxt = ttep_pkg::PH_MIN;
            cnt_nxt   = '0;
          end else if (c == ttep_pkg::CH_DOT && cnt_r >= 5'd1) begin
            phase_nxt = ttep_pkg::PH_OFRAC;
            cnt_nxt   = '0;
          end else if (cnt_r >= 5'd1 && is_unit) begin
            unit_nxt  = unit_c;
            phase_nxt = ttep_pkg::PH_UNIT;
          end else begin
            phase_nxt = ttep_pkg::PH_ERR;
          end
        end
        ttep_pkg::PH_MIN: begin
          if (dig && cnt_r < 5'd2) begin
            min_nxt = ttep_pkg::MIN_W'(({3'b0, min_r} << 3) + ({3'b0, min_r} << 1) + d);
            cnt_nxt = cnt_inc;
          end else if (c == ttep_pkg::CH_COLON && cnt_r == 5'd2) begin
            phase_nxt = ttep_pkg::PH_SEC;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = ttep_pkg::PH_ERR;
          end
        end
        ttep_pkg::PH_SEC: begin
          if (dig && cnt_r < 5'd2) begin
            sec_nxt = ttep_pkg::MIN_W'(({3'b0, sec_r} << 3) + ({3'b0, sec_r} << 1) + d);
            cnt_nxt = cnt_inc;
          end else if (c == ttep_pkg::CH_DOT && cnt_r == 5'd2) begin
            phase_nxt = ttep_pkg::PH_CFRAC;
            cnt_nxt   = '0;
          end else if (c == ttep_pkg::CH_COLON && cnt_r == 5'd2) begin
            phase_nxt = ttep_pkg::PH_FRM;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = ttep_pkg::PH_ERR;
          end
        end
        ttep_pkg::PH_CFRAC, ttep_pkg::PH_OFRAC: begin
          if (dig) begin
            if (fd_r < FD_W'(MAX_FRACTION_DIGITS)) begin
              frac_nxt = frac10[FRAC_W-1:0];
              fd_nxt   = fd_r + 1'b1;
            end
            cnt_nxt = cnt_inc;
          end else if (phase_r == ttep_pkg::PH_OFRAC && cnt_r >= 5'd1 && is_unit) begin
            unit_nxt  = unit_c;
            phase_nxt = ttep_pkg::PH_UNIT;
          end else begin
            phase_nxt = ttep_pkg::PH_ERR;
          end
        end
        ttep_pkg::PH_FRM: begin
          if (dig && cnt_r < 5'd2) begin
            frm_nxt = ttep_pkg::FRM_W'(({3'b0, frm_r} << 3) + ({3'b0, frm_r} << 1) + d);
            cnt_nxt = cnt_inc;
          end else if (c == ttep_pkg::CH_DOT && cnt_r == 5'd2) begin
            phase_nxt = ttep_pkg::PH_SUB;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = ttep_pkg::PH_ERR;
          end
        end
        ttep_pkg::PH_SUB: begin
          if (dig) begin
            sub_nxt = (sub10 > {4'b0, ttep_pkg::SUB_MAX}) ? ttep_pkg::SUB_MAX
                                                          : sub10[ttep_pkg::SUB_W-1:0];
            cnt_nxt = cnt_inc;
          end else begin
            phase_nxt = ttep_pkg::PH_ERR;
          end
        end
        ttep_pkg::PH_UNIT: begin
          if (unit_r == ttep_pkg::U_M && c == ttep_pkg::CH_S) begin
            unit_nxt = ttep_pkg::U_MS;
          end else begin
            phase_nxt = ttep_pkg::PH_ERR;
          end
        end
        default: phase_nxt = ttep_pkg::PH_ERR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ttep_pkg::PH_LEAD;
      unit_r  <= ttep_pkg::U_H;
      lead_r  <= '0;
      min_r   <= '0;
      sec_r   <= '0;
      frm_r   <= '0;
      sub_r   <= '0;
      frac_r  <= '0;
      fd_r    <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      unit_r  <= unit_nxt;
      lead_r  <= lead_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      frm_r   <= frm_nxt;
      sub_r   <= sub_nxt;
      frac_r  <= frac_nxt;
      fd_r    <= fd_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // ---- status to the sequencer ----
  logic ok;
  always_comb begin
    case (phase_r)
      ttep_pkg::PH_SEC, ttep_pkg::PH_FRM:   ok = (cnt_r == 5'd2);
      ttep_pkg::PH_CFRAC, ttep_pkg::PH_SUB: ok = (cnt_r >= 5'd1);
      ttep_pkg::PH_UNIT:                    ok = 1'b1;
      default:                              ok = 1'b0;
    endcase
  end

  logic                         div_done;
  logic [ttep_pkg::DNUM_W-1:0]  div_q;
  logic [ttep_pkg::DDEN_W-1:0]  div_r;

  assign sts.ok        = ok;
  assign sts.phase     = phase_r;
  assign sts.rate_unit = (unit_r == ttep_pkg::U_F) || (unit_r == ttep_pkg::U_T);
  assign sts.div_done  = div_done;

  // ---- effective rates and scale constants ----
  logic [ttep_pkg::FR_W-1:0]  fr_eff, sr_eff;
  logic [ttep_pkg::TR_W-1:0]  tr_eff, rate_val;
  logic [ttep_pkg::DEN_W-1:0] den_val;
  logic [ttep_pkg::MUL_W-1:0] unit_k, lead_k;

  assign fr_eff   = (frame_rate == '0) ? ttep_pkg::FR_W'(1) : frame_rate;
  assign sr_eff   = (subframe_rate == '0) ? ttep_pkg::FR_W'(1) : subframe_rate;
  assign tr_eff   = (tick_rate == '0) ? ttep_pkg::TR_W'(1) : tick_rate;
  assign rate_val = (unit_r == ttep_pkg::U_F) ? ttep_pkg::TR_W'(fr_eff) : tr_eff;
  assign den_val  = ttep_pkg::pow10(4'(fd_r));

  always_comb begin
    case (unit_r)
      ttep_pkg::U_H:  unit_k = ttep_pkg::K_HOUR;
      ttep_pkg::U_M:  unit_k = ttep_pkg::K_MIN;
      ttep_pkg::U_MS: unit_k = ttep_pkg::K_MS;
      default:        unit_k = ttep_pkg::K_SEC;
    endcase
  end
  assign lead_k = (phase_r == ttep_pkg::PH_UNIT) ? unit_k : ttep_pkg::K_HOUR;

  // ---- multiplier ----
  logic [ttep_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [ttep_pkg::PROD_W-1:0] m_r, t_r;
  localparam int HALF_W = ttep_pkg::LEAD_W / 2;

  always_comb begin
    case (cmd.mul_a)
      ttep_pkg::MA_LEAD_HI: mul_a = ttep_pkg::MUL_W'(lead_r[ttep_pkg::LEAD_W-1:HALF_W]);
      ttep_pkg::MA_LEAD_LO: mul_a = ttep_pkg::MUL_W'(lead_r[HALF_W-1:0]);
      ttep_pkg::MA_FRAC:    mul_a = ttep_pkg::MUL_W'(frac_r);
      ttep_pkg::MA_REM:     mul_a = div_r[ttep_pkg::MUL_W-1:0];
      ttep_pkg::MA_DEN:     mul_a = ttep_pkg::MUL_W'(den_val);
      ttep_pkg::MA_MIN:     mul_a = ttep_pkg::MUL_W'(min_r);
      ttep_pkg::MA_SEC:     mul_a = ttep_pkg::MUL_W'(sec_r);
      ttep_pkg::MA_FRM:     mul_a = ttep_pkg::MUL_W'(frm_r);
      ttep_pkg::MA_SUB:     mul_a = ttep_pkg::MUL_W'(sub_r);
      ttep_pkg::MA_SR:      mul_a = ttep_pkg::MUL_W'(sr_eff);
      default:              mul_a = '0;
    endcase
    case (cmd.mul_b)
      ttep_pkg::MB_LEADK: mul_b = lead_k;
      ttep_pkg::MB_UNITK: mul_b = unit_k;
      ttep_pkg::MB_US:    mul_b = ttep_pkg::K_SEC;
      ttep_pkg::MB_MINK:  mul_b = ttep_pkg::K_MIN;
      ttep_pkg::MB_DEN:   mul_b = ttep_pkg::MUL_W'(den_val);
      ttep_pkg::MB_RATE:  mul_b = ttep_pkg::MUL_W'(rate_val);
      ttep_pkg::MB_FR:    mul_b = ttep_pkg::MUL_W'(fr_eff);
      default:            mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      m_r <= mul_a * mul_b;
    end
    case (cmd.t_op)
      ttep_pkg::T_LOADM: t_r <= m_r;
      ttep_pkg::T_ADDM:  t_r <= t_r + m_r;
      default:           t_r <= t_r;
    endcase
  end

  // ---- saturated wide product from the two half products ----
  logic [ttep_pkg::TIME_W-1:0] prod_sat;
  logic [ttep_pkg::PROD_W-1:0] prod_sum;
  localparam int HI_KEEP = ttep_pkg::TIME_W - HALF_W;

  assign prod_sum = {1'b0, t_r[HI_KEEP-1:0], {HALF_W{1'b0}}} + m_r;
  assign prod_sat = (t_r[ttep_pkg::PROD_W-1:HI_KEEP] != '0 ||
                     prod_sum[ttep_pkg::PROD_W-1]) ? ttep_pkg::TIME_MAX
                                                   : prod_sum[ttep_pkg::TIME_W-1:0];

  // ---- divider ----
  logic [ttep_pkg::DNUM_W-1:0] div_num;
  logic [ttep_pkg::DDEN_W-1:0] div_den;

  always_comb begin
    case (cmd.div_num)
      ttep_pkg::DN_ACC: div_num = ttep_pkg::DNUM_W'(acc_r);
      ttep_pkg::DN_T:   div_num = t_r;
      default:          div_num = m_r;
    endcase
    case (cmd.div_den)
      ttep_pkg::DD_RATE: div_den = ttep_pkg::DDEN_W'(rate_val);
      ttep_pkg::DD_FR:   div_den = ttep_pkg::DDEN_W'(fr_eff);
      ttep_pkg::DD_M:    div_den = m_r[ttep_pkg::DDEN_W-1:0];
      ttep_pkg::DD_T:    div_den = t_r[ttep_pkg::DDEN_W-1:0];
      default:           div_den = ttep_pkg::DDEN_W'(den_val);
    endcase
  end

  ttep_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_r)
  );

  // ---- accumulator and result ----
  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      ttep_pkg::ACC_CLR:   acc_r <= '0;
      ttep_pkg::ACC_PROD:  acc_r <= prod_sat;
      ttep_pkg::ACC_ADDM:  acc_r <= ttep_pkg::sat_add(acc_r, m_r);
      ttep_pkg::ACC_ADDQ:  acc_r <= ttep_pkg::sat_add(acc_r, div_q);
      ttep_pkg::ACC_LOADQ: acc_r <= div_q[ttep_pkg::TIME_W-1:0];
      default:             acc_r <= acc_r;
    endcase
    if (cmd.eval) begin
      mal_r <= !ok;
    end
  end

  assign out_data.time_us   = acc_r;
  assign out_data.malformed = mal_r;

endmodule

// ----- rtl/core/ttep_checker.sv -----
// ----------------------------------------------------------------------------
// ttep_checker
// Port-level checks for the time expression parser, bound to the top level.
// ----------------------------------------------------------------------------
module ttep_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ttep_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // malformed results carry zero time
  a_mal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.malformed |-> out_data.time_us == '0)
    else $error("malformed result with nonzero time");

  // no new characters while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  // one result per expression
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result repeated");

endmodule

bind timed_text_time_expression_parser ttep_checker u_ttep_checker (.*);

// ----- tb/timed_text_time_expression_parser_tb.sv -----
// ----------------------------------------------------------------------------
// timed_text_time_expression_parser_tb
// Sends clock-form, offset-form, broken and noise expressions one character
// per request under several rate settings and idle patterns, predicts each
// parsed time and checks every result in order against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_text_time_expression_parser_tb;

  localparam longint unsigned T_SAT    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned LEAD_SAT = 64'h00FF_FFFF_FFFF;
  localparam longint unsigned SUB_SAT  = 64'hF_FFFF;
  localparam longint unsigned US       = 64'd1000000;
  localparam int FRAC_KEEP  = 6;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 300;

  // expected parse results, with a running copy of the parser state
  class parse_scoreboard;
    int unsigned fr_rate, sf_rate, tk_rate;
    ttep_pkg::phase_t ph;
    ttep_pkg::unit_t unit;
    longint unsigned lead, mins, secs, frms, subf, fval;
    int unsigned fdig, cnt;
    ttep_pkg::out_item_t expected_times[$];

    function new();
      fr_rate = 30; sf_rate = 1; tk_rate = 1;
      clear();
    endfunction

    function void clear();
      ph = ttep_pkg::PH_LEAD; unit = ttep_pkg::U_H;
      lead = 0; mins = 0; secs = 0; frms = 0; subf = 0; fval = 0;
      fdig = 0; cnt = 0;
    endfunction

    function void set_rate(logic [1:0] idx, logic [31:0] v);
      case (idx)
        ttep_pkg::REG_FRAME_RATE:    fr_rate = v[9:0];
        ttep_pkg::REG_SUBFRAME_RATE: sf_rate = v[9:0];
        ttep_pkg::REG_TICK_RATE:     tk_rate = v[23:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_times.size();
    endfunction

    function longint unsigned sadd(longint unsigned a, longint unsigned b);
      if (a > T_SAT || b > T_SAT - a) return T_SAT;
      return a + b;
    endfunction

    function longint unsigned smul(longint unsigned a, longint unsigned k);
      if (k != 0 && a > T_SAT / k) return T_SAT;
      return a * k;
    endfunction

    function longint unsigned den();
      longint unsigned p;
      p = 1;
      for (int i = 0; i < fdig && i < 9; i++) p = p * 10;
      return p;
    endfunction

    function bit unit_of(logic [7:0] c, output ttep_pkg::unit_t u);
      u = ttep_pkg::U_H;
      case (c)
        ttep_pkg::CH_H: u = ttep_pkg::U_H;
        ttep_pkg::CH_M: u = ttep_pkg::U_M;
        ttep_pkg::CH_S: u = ttep_pkg::U_S;
        ttep_pkg::CH_F: u = ttep_pkg::U_F;
        ttep_pkg::CH_T: u = ttep_pkg::U_T;
        default: return 0;
      endcase
      return 1;
    endfunction

    function void frac_digit(longint unsigned d);
      if (fdig < FRAC_KEEP && fdig < 9) begin
        fval = fval * 10 + d;
        fdig++;
      end
      if (cnt < 31) cnt++;
    endfunction

    // exact floor of (lead + fraction) * 1e6 / rate
    function longint unsigned by_rate(longint unsigned rate);
      longint unsigned dn, a, q, r;
      dn = den();
      a = lead * US;
      q = a / rate;
      r = a % rate;
      return sadd(q, (r * dn + fval * US) / (dn * rate));
    endfunction

    function longint unsigned off_form_us();
      longint unsigned k;
      case (unit)
        ttep_pkg::U_H:  k = 64'd3600 * US;
        ttep_pkg::U_M:  k = 64'd60 * US;
        ttep_pkg::U_S:  k = US;
        ttep_pkg::U_MS: k = 64'd1000;
        ttep_pkg::U_F:  return by_rate(fr_rate == 0 ? 1 : fr_rate);
        default: return by_rate(tk_rate == 0 ? 1 : tk_rate);
      endcase
      return sadd(smul(lead, k), fval * k / den());
    endfunction

    function longint unsigned clk_form_us();
      longint unsigned fr, sr, v;
      fr = fr_rate == 0 ? 1 : fr_rate;
      sr = sf_rate == 0 ? 1 : sf_rate;
      v = smul(lead, 64'd3600 * US);
      v = sadd(v, mins * 60 * US);
      v = sadd(v, secs * US);
      if (ph == ttep_pkg::PH_CFRAC) v = sadd(v, fval * US / den());
      if (ph == ttep_pkg::PH_FRM || ph == ttep_pkg::PH_SUB) v = sadd(v, frms * US / fr);
      if (ph == ttep_pkg::PH_SUB) v = sadd(v, subf * US / (sr * fr));
      return v;
    endfunction

    function void advance(logic [7:0] c);
      bit dig;
      longint unsigned d;
      ttep_pkg::unit_t u;
      dig = c >= ttep_pkg::CH_0 && c <= ttep_pkg::CH_9;
      d = dig ? longint'(c - ttep_pkg::CH_0) : 0;
      case (ph)
        ttep_pkg::PH_LEAD: begin
          if (dig) begin
            lead = lead > (LEAD_SAT - d) / 10 ? LEAD_SAT : lead * 10 + d;
            if (cnt < 31) cnt++;
          end else if (c == ttep_pkg::CH_COLON && cnt >= 2) begin
            ph = ttep_pkg::PH_MIN; cnt = 0;
          end else if (c == ttep_pkg::CH_DOT && cnt >= 1) begin
            ph = ttep_pkg::PH_OFRAC; cnt = 0;
          end else if (cnt >= 1 && unit_of(c, u)) begin
            unit = u; ph = ttep_pkg::PH_UNIT;
          end else ph = ttep_pkg::PH_ERR;
        end
        ttep_pkg::PH_MIN: begin
          if (dig && cnt < 2) begin
            mins = mins * 10 + d; cnt++;
          end else if (c == ttep_pkg::CH_COLON && cnt == 2) begin
            ph = ttep_pkg::PH_SEC; cnt = 0;
          end else ph = ttep_pkg::PH_ERR;
        end
        ttep_pkg::PH_SEC: begin
          if (dig && cnt < 2) begin
            secs = secs * 10 + d; cnt++;
          end else if (c == ttep_pkg::CH_DOT && cnt == 2) begin
            ph = ttep_pkg::PH_CFRAC; cnt = 0;
          end else if (c == ttep_pkg::CH_COLON && cnt == 2) begin
            ph = ttep_pkg::PH_FRM; cnt = 0;
          end else ph = ttep_pkg::PH_ERR;
        end
        ttep_pkg::PH_CFRAC: begin
          if (dig) frac_digit(d);
          else ph = ttep_pkg::PH_ERR;
        end
        ttep_pkg::PH_FRM: begin
          if (dig && cnt < 2) begin
            frms = frms * 10 + d; cnt++;
          end else if (c == ttep_pkg::CH_DOT && cnt == 2) begin
            ph = ttep_pkg::PH_SUB; cnt = 0;
          end else ph = ttep_pkg::PH_ERR;
        end
        ttep_pkg::PH_SUB: begin
          if (dig) begin
            subf = subf > (SUB_SAT - d) / 10 ? SUB_SAT : subf * 10 + d;
            if (cnt < 31) cnt++;
          end else ph = ttep_pkg::PH_ERR;
        end
        ttep_pkg::PH_OFRAC: begin
          if (dig) frac_digit(d);
          else if (cnt >= 1 && unit_of(c, u)) begin
            unit = u; ph = ttep_pkg::PH_UNIT;
          end else ph = ttep_pkg::PH_ERR;
        end
        ttep_pkg::PH_UNIT: begin
          if (unit == ttep_pkg::U_M && c == ttep_pkg::CH_S) unit = ttep_pkg::U_MS;
          else ph = ttep_pkg::PH_ERR;
        end
        default: ph = ttep_pkg::PH_ERR;
      endcase
    endfunction

    // one accepted character request
    function void note_request(ttep_pkg::in_item_t it);
      bit ok;
      ttep_pkg::out_item_t r;
      advance(it.char_in);
      if (!it.last_char) return;
      case (ph)
        ttep_pkg::PH_SEC, ttep_pkg::PH_FRM:   ok = cnt == 2;
        ttep_pkg::PH_CFRAC, ttep_pkg::PH_SUB: ok = cnt >= 1;
        ttep_pkg::PH_UNIT:                    ok = 1;
        default:                              ok = 0;
      endcase
      r.time_us = '0;
      if (ok) begin
        r.time_us = (ph == ttep_pkg::PH_UNIT) ? ttep_pkg::TIME_W'(off_form_us())
                                              : ttep_pkg::TIME_W'(clk_form_us());
      end
      r.malformed = !ok;
      expected_times.push_back(r);
      clear();
    endfunction

    function bit check_result(ttep_pkg::out_item_t got, output string msg);
      ttep_pkg::out_item_t e;
      msg = "";
      if (expected_times.size() == 0) begin
        msg = $sformatf("result with nothing expected: time %0d malformed %0b",
                        got.time_us, got.malformed);
        return 0;
      end
      e = expected_times.pop_front();
      if (got.time_us !== e.time_us)
        msg = $sformatf("time_us %0d, expected %0d", got.time_us, e.time_us);
      if (got.malformed !== e.malformed)
        msg = {msg, $sformatf(" malformed %0b, expected %0b", got.malformed,
                              e.malformed)};
      return msg == "";
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  ttep_pkg::in_item_t in_data;
  ttep_pkg::out_item_t out_data;
  logic psel, penable, pwrite, pready;
  logic [ttep_pkg::CFG_AW-1:0] paddr;
  logic [ttep_pkg::CFG_DW-1:0] pwdata, prdata;

  parse_scoreboard sb;
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet = 0;

  timed_text_time_expression_parser i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // result side: random stalls, check on every accepted result
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && out_ready) begin
      if (!sb.check_result(out_data, msg)) report(msg);
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("timed_text_time_expression_parser_tb: errors");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_rate(idx, v);
  endtask

  // drive one expression, a character per request; valid stays up for the
  // next expression or is dropped by the drain wait
  task automatic send_expr(byte unsigned q[$]);
    ttep_pkg::in_item_t it;
    foreach (q[i]) begin
      while ($urandom_range(99) < idle_pct) begin
        in_valid <= 0;
        @(negedge clk);
      end
      it.char_in = q[i];
      it.last_char = (i == q.size() - 1);
      in_valid <= 1;
      in_data <= it;
      do @(posedge clk); while (!in_ready);
      sb.note_request(it);
      @(negedge clk);
    end
  endtask

  task automatic send_text(string s);
    byte unsigned q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_expr(q);
  endtask

  task automatic add_digits(ref byte unsigned q[$], input int n);
    repeat (n) q.push_back(ttep_pkg::CH_0 + 8'($urandom_range(9)));
  endtask

  function automatic int lead_len(int lo);
    return ($urandom_range(9) == 0) ? $urandom_range(12, 16) : $urandom_range(lo, 3);
  endfunction

  // well-formed expression with random content
  task automatic build_good(ref byte unsigned q[$]);
    int k;
    k = $urandom_range(6);
    if (k < 4) begin
      add_digits(q, lead_len(2));
      q.push_back(ttep_pkg::CH_COLON); add_digits(q, 2);
      q.push_back(ttep_pkg::CH_COLON); add_digits(q, 2);
      if (k == 1) begin
        q.push_back(ttep_pkg::CH_DOT); add_digits(q, $urandom_range(1, 9));
      end else if (k >= 2) begin
        q.push_back(ttep_pkg::CH_COLON); add_digits(q, 2);
        if (k == 3) begin
          q.push_back(ttep_pkg::CH_DOT); add_digits(q, $urandom_range(1, 8));
        end
      end
    end else begin
      add_digits(q, lead_len(1));
      if ($urandom_range(1)) begin
        q.push_back(ttep_pkg::CH_DOT); add_digits(q, $urandom_range(1, 9));
      end
      case ($urandom_range(5))
        0: q.push_back(ttep_pkg::CH_H);
        1: q.push_back(ttep_pkg::CH_M);
        2: q.push_back(ttep_pkg::CH_S);
        3: begin q.push_back(ttep_pkg::CH_M); q.push_back(ttep_pkg::CH_S); end
        4: q.push_back(ttep_pkg::CH_F);
        default: q.push_back(ttep_pkg::CH_T);
      endcase
    end
  endtask

  task automatic random_expr();
    byte unsigned q[$];
    int k;
    k = $urandom_range(9);
    if (k == 9) begin
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(255)));
    end else begin
      build_good(q);
      if (k == 8) q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
      else if (k == 7 && q.size() > 1) q = q[0:$urandom_range(q.size() - 2)];
    end
    send_expr(q);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int mode;
    int sent;
    sb = new();
    rst_n = 0; in_valid = 0; in_data = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: field extremes, the h, ms, f and t units, each special case
    send_text("00:00:00");
    send_text("99:59:59.1234567");
    send_text("01:02:03:29.7");
    send_text("1.5h");
    send_text("2ms");
    send_text("7.25f");
    send_text("99999999999999999h");
    send_text("00:00:00:00.99999999");
    send_text("1.t");
    send_text("5mm");
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin cfg_write(ttep_pkg::REG_FRAME_RATE, 1);
                 cfg_write(ttep_pkg::REG_SUBFRAME_RATE, 1);
                 cfg_write(ttep_pkg::REG_TICK_RATE, 1); end
        1: begin cfg_write(ttep_pkg::REG_FRAME_RATE, 1000);
                 cfg_write(ttep_pkg::REG_SUBFRAME_RATE, 1000);
                 cfg_write(ttep_pkg::REG_TICK_RATE, 24'hFFFFFF); end
        2: begin cfg_write(ttep_pkg::REG_FRAME_RATE, 0);
                 cfg_write(ttep_pkg::REG_SUBFRAME_RATE, 0);
                 cfg_write(ttep_pkg::REG_TICK_RATE, 0); end
        default: begin
          cfg_write(ttep_pkg::REG_FRAME_RATE, {$urandom} | 32'h1);
          cfg_write(ttep_pkg::REG_SUBFRAME_RATE, $urandom_range(1, 1000));
          cfg_write(ttep_pkg::REG_TICK_RATE, $urandom);
        end
      endcase
      mode = p % 4;
      idle_pct  = (mode == 1) ? 70 : (mode == 3) ? 18 : 0;
      stall_pct = (mode == 2) ? 70 : (mode == 3) ? 18 : 0;
      sent = 0;
      while (sent < 130) begin
        random_expr();
        sent += 10;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("timed_text_time_expression_parser_tb: clean");
    end else begin
      $display("timed_text_time_expression_parser_tb: errors");
    end
    $finish;
  end

endmodule
